### sv/rc5it_pkg.sv
// Package for the RC5 infrared transceiver: item types, register set, codes
// and frame constants. Used by rc5it_core and rc5_infrared_transceiver.
// No dependencies.
package rc5it_pkg;

  localparam int unsigned FRAME_BITS = 14;
  localparam int unsigned RX_BITS    = 12;

  localparam logic [7:0] SILENCE_RST   = 8'd150;
  localparam logic [7:0] HALF_BIT_RST  = 8'd34;
  localparam logic [4:0] ADDRESS_RST   = 5'd29;
  localparam logic [7:0] MEASURE_START = 8'hFF;
  localparam logic [3:0] RX_FIRST_IDX  = 4'd12;
  localparam logic [1:0] START_BITS    = 2'b11;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_EDGE     = 2'd1,
    CMD_SEND     = 2'd2,
    CMD_RECEIVE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SILENCE  = 2'd0,
    REG_HALF_BIT = 2'd1,
    REG_ADDRESS  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] command;
    logic       rx_level;
    logic [5:0] tx_address;
    logic [5:0] tx_opcode;
  } in_item_t;

  typedef struct packed {
    logic        led_on;
    logic        edge_armed;
    logic        frame_done;
    logic [11:0] frame_code;
    logic [5:0]  ir_opcode;
    logic        ir_valid;
    logic        ir_toggle;
    logic        sending;
  } out_item_t;

  typedef struct packed {
    logic [7:0] silence_ticks;
    logic [7:0] send_half_bit_ticks;
    logic [4:0] accepted_address;
  } cfg_regs_t;

  // Mode flags of the transceiver; hold marks the inter-bit quiet wait.
  typedef struct packed {
    logic mode;
    logic fin;
    logic meas;
    logic recv;
    logic hold;
    logic phase;
    logic emit;
  } flags_t;

endpackage

### sv/rc5_infrared_transceiver.sv
// Top level of the RC5 infrared transceiver: input register, configuration
// registers and result register around rc5it_core. Depends on rc5it_pkg.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item  (in_item_t)
//   out_     output     out_valid/out_stall out_item (out_item_t)
//   cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle is sustained while the output is not stalled; each item
// passes the input register, one pass of the state update in rc5it_core, and
// the result register.
// Synchronous active-low reset restores the register defaults and clears the valid
// flags and core state. A stalled output holds its result; the input stalls only
// while a held item cannot move into the result register.
module rc5_infrared_transceiver import rc5it_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  in_item_t  item_r;
  logic      item_v_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  cfg_regs_t cfg_r;
  out_item_t result;
  logic      fire;
  logic      in_take;

  assign fire      = item_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = item_v_r && !fire;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rc5it_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.silence_ticks       <= SILENCE_RST;
      cfg_r.send_half_bit_ticks <= HALF_BIT_RST;
      cfg_r.accepted_address    <= ADDRESS_RST;
    end else begin
      if (in_take) begin
        item_v_r <= 1'b1;
      end else if (fire) begin
        item_v_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SILENCE:  cfg_r.silence_ticks       <= cfg_data;
          REG_HALF_BIT: cfg_r.send_half_bit_ticks <= cfg_data;
          REG_ADDRESS:  cfg_r.accepted_address    <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

`ifndef SYNTHESIS
  // A completed frame reports the command bits it just assembled.
  a_done_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_done |-> out_item.ir_opcode == out_item.frame_code[5:0])
    else $error("frame report does not match received bits");

  // Receiver edges are never armed while transmitting.
  a_send_no_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.sending |-> !out_item.edge_armed)
    else $error("edges armed during send");

  // The input side stalls only when an item is waiting in the input register.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_v_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked item");
`endif

endmodule

### sv/rc5it_core.sv
// State of the RC5 transceiver and its per-item update logic.
// Depends on rc5it_pkg; instantiated by rc5_infrared_transceiver.
module rc5it_core import rc5it_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  flags_t                  flags_r, flags_nxt;
  logic [7:0]              tick_r, tick_nxt;
  logic [3:0]              bit_idx_r, bit_idx_nxt;
  logic [7:0]              half_len_r, half_len_nxt;
  logic [FRAME_BITS-1:0]   tx_frame_r, tx_frame_nxt;
  logic [RX_BITS-1:0]      rx_frame_r, rx_frame_nxt;
  logic                    timer_on_r, timer_on_nxt;
  logic                    edges_on_r, edges_on_nxt;
  logic [7:0]              report_r, report_nxt;
  logic                    done;
  logic [7:0]              period;
  logic [8:0]              scaled;

  always_comb begin
    flags_nxt    = flags_r;
    tick_nxt     = tick_r;
    bit_idx_nxt  = bit_idx_r;
    half_len_nxt = half_len_r;
    tx_frame_nxt = tx_frame_r;
    rx_frame_nxt = rx_frame_r;
    timer_on_nxt = timer_on_r;
    edges_on_nxt = edges_on_r;
    report_nxt   = report_r;
    done         = 1'b0;
    period       = MEASURE_START - tick_r;
    // 1.5 times the measured half bit, kept to eight bits.
    scaled       = {period, 1'b0} - {2'b00, period[7:1]};

    unique case (cmd_t'(item.command))
      CMD_TICK: begin
        if (timer_on_r) begin
          if (tick_r != 8'd0) begin
            tick_nxt = tick_r - 8'd1;
          end else if (flags_r.mode) begin
            if (flags_r.hold) begin
              flags_nxt.fin  = 1'b1;
              flags_nxt.recv = 1'b0;
              flags_nxt.hold = 1'b0;
              tick_nxt       = cfg.silence_ticks;
            end else if (flags_r.recv) begin
              bit_idx_nxt = bit_idx_r - 4'd1;
              if (item.rx_level && bit_idx_nxt < RX_FIRST_IDX) begin
                rx_frame_nxt[bit_idx_nxt] = 1'b1;
              end
              if (bit_idx_nxt == 4'd0) begin
                flags_nxt.fin  = 1'b1;
                flags_nxt.recv = 1'b0;
                report_nxt = {rx_frame_nxt[11],
                              rx_frame_nxt[10:6] == cfg.accepted_address,
                              rx_frame_nxt[5:0]};
                done = 1'b1;
              end else begin
                flags_nxt.hold = 1'b1;
              end
              tick_nxt     = cfg.silence_ticks;
              edges_on_nxt = 1'b1;
            end else if (flags_r.fin) begin
              flags_nxt.fin = 1'b0;
              timer_on_nxt  = 1'b0;
            end
          end else begin
            if (flags_r.phase) begin
              flags_nxt.emit  = ~flags_r.emit;
              flags_nxt.phase = 1'b0;
              tick_nxt        = half_len_r;
            end else if (bit_idx_r != 4'd0) begin
              bit_idx_nxt     = bit_idx_r - 4'd1;
              // A zero bit drives the LED in its first half.
              flags_nxt.emit  = ~tx_frame_r[bit_idx_nxt];
              flags_nxt.phase = 1'b1;
              tick_nxt        = half_len_r;
            end else begin
              flags_nxt.fin  = 1'b1;
              flags_nxt.mode = 1'b1;
              flags_nxt.emit = 1'b0;
              tick_nxt       = cfg.silence_ticks;
              edges_on_nxt   = 1'b1;
            end
          end
        end
      end
      CMD_EDGE: begin
        if (edges_on_r) begin
          if (flags_r.fin) begin
            tick_nxt = cfg.silence_ticks;
          end else if (flags_r.meas) begin
            timer_on_nxt   = 1'b0;
            half_len_nxt   = scaled[7:0];
            flags_nxt.meas = 1'b0;
            flags_nxt.recv = 1'b1;
            bit_idx_nxt    = RX_FIRST_IDX;
            rx_frame_nxt   = '0;
          end else if (flags_r.recv) begin
            tick_nxt       = half_len_r;
            timer_on_nxt   = 1'b1;
            flags_nxt.hold = 1'b0;
            edges_on_nxt   = 1'b0;
          end else begin
            tick_nxt       = MEASURE_START;
            timer_on_nxt   = 1'b1;
            flags_nxt.meas = 1'b1;
          end
        end
      end
      CMD_SEND: begin
        edges_on_nxt = 1'b0;
        flags_nxt    = '0;
        bit_idx_nxt  = 4'(FRAME_BITS);
        tick_nxt     = 8'd0;
        tx_frame_nxt = {START_BITS, item.tx_address, item.tx_opcode};
        half_len_nxt = cfg.send_half_bit_ticks;
        timer_on_nxt = 1'b1;
      end
      CMD_RECEIVE: begin
        flags_nxt      = '0;
        flags_nxt.mode = 1'b1;
        flags_nxt.fin  = 1'b1;
        tick_nxt       = cfg.silence_ticks;
        timer_on_nxt   = 1'b1;
        edges_on_nxt   = 1'b1;
      end
    endcase

    result.led_on     = flags_nxt.emit;
    result.edge_armed = edges_on_nxt;
    result.frame_done = done;
    result.frame_code = rx_frame_nxt;
    result.ir_opcode  = report_nxt[5:0];
    result.ir_valid   = report_nxt[6];
    result.ir_toggle  = report_nxt[7];
    result.sending    = ~flags_nxt.mode & timer_on_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      tick_r     <= '0;
      bit_idx_r  <= '0;
      half_len_r <= '0;
      tx_frame_r <= '0;
      rx_frame_r <= '0;
      timer_on_r <= 1'b0;
      edges_on_r <= 1'b0;
      report_r   <= '0;
    end else if (fire) begin
      flags_r    <= flags_nxt;
      tick_r     <= tick_nxt;
      bit_idx_r  <= bit_idx_nxt;
      half_len_r <= half_len_nxt;
      tx_frame_r <= tx_frame_nxt;
      rx_frame_r <= rx_frame_nxt;
      timer_on_r <= timer_on_nxt;
      edges_on_r <= edges_on_nxt;
      report_r   <= report_nxt;
    end
  end

endmodule
